FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent true implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent true implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/mmu_pkg.sv
// ----------------------------------------------------------------------------
// mmu_pkg
// Shared types and constants for the matrix multiply unit.
// ----------------------------------------------------------------------------
package mmu_pkg;

    // Configuration register file
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } cfg_reg_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD  = 2'd0,
        ST_MAC   = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // store one element this cycle
        logic issue;  // issue one multiply-accumulate step
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic load_done;   // element being stored completes the load
        logic issue_last;  // step being issued is the final one of the run
        logic final_out;   // final product entry is on the outputs now
    } ctrl_sts_t;

endpackage

FILE: rtl/core/matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_unit
// Streaming dense matrix multiply C = A * B, row major, signed Q8.8 in and
// exact Q19.16 out.
// ----------------------------------------------------------------------------
// Elements of A and then of B are taken one per cycle while busy is low and
// start is high. The item that completes B raises busy; a single
// multiply-accumulate unit then walks the product, one step per cycle, for
// rows_a * cols_b * inner_dim steps, through a pipeline of store read,
// multiply and accumulate into the output register. Each product entry is
// shown for exactly one cycle with result_valid and cannot be held off; the
// last one carries last_entry, and busy drops the cycle after it. Over a full
// 8x8x8 run (128 loads) the time is set by the one MAC unit, and no new
// element is taken until busy drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_multiply_unit #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ELEM_WIDTH-1:0]        element_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmu_pkg::CFG_W-1:0]           cfg_data,
    output logic                                result_valid,
    output logic signed [2*ELEM_WIDTH+$clog2(MAX_DIM)-1:0] product_value,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] row_index,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] col_index,
    output logic                                last_entry
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PROD_W = 2 * ELEM_WIDTH + $clog2(MAX_DIM);

    mmu_pkg::ctrl_cmd_t cmd;
    mmu_pkg::ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer
    mmu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Stores and MAC pipeline
    mmu_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .IDX_W      (IDX_W),
        .PROD_W     (PROD_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_value (element_value),
        .product_value (product_value),
        .row_index     (row_index),
        .col_index     (col_index),
        .last_entry    (last_entry),
        .result_valid  (result_valid)
    );

    // Results only appear during a run
    `ASSERT_SAME(a_result_in_run, clk, rst_n, result_valid, busy)
    // The final entry ends the run
    `ASSERT_NEXT(a_last_ends_run, clk, rst_n, result_valid && last_entry, !busy)
    // A non-final entry leaves the run going
    `ASSERT_NEXT(a_mid_keeps_run, clk, rst_n, result_valid && !last_entry, busy)

endmodule

FILE: rtl/core/mmu_ram.sv
// ----------------------------------------------------------------------------
// mmu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mmu_ctrl.sv
// ----------------------------------------------------------------------------
// mmu_ctrl
// Sequencer: load phase, multiply-accumulate phase, pipeline drain.
// ----------------------------------------------------------------------------
module mmu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mmu_pkg::ctrl_sts_t sts,
    output mmu_pkg::ctrl_cmd_t cmd,
    output logic               busy
);

    mmu_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmu_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmu_pkg::ST_LOAD:
            begin
                if (start && sts.load_done)
                begin
                    state_next = mmu_pkg::ST_MAC;
                end
            end
            mmu_pkg::ST_MAC:
            begin
                if (sts.issue_last)
                begin
                    state_next = mmu_pkg::ST_DRAIN;
                end
            end
            mmu_pkg::ST_DRAIN:
            begin
                if (sts.final_out)
                begin
                    state_next = mmu_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mmu_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            mmu_pkg::ST_LOAD:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            mmu_pkg::ST_MAC:
            begin
                cmd.issue = 1'b1;
            end
            mmu_pkg::ST_DRAIN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/mmu_datapath.sv
// ----------------------------------------------------------------------------
// mmu_datapath
// Size registers, element stores, step counters and the single MAC pipeline.
// ----------------------------------------------------------------------------
module mmu_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16,
    parameter int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int PROD_W     = 2 * ELEM_WIDTH + $clog2(MAX_DIM)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mmu_pkg::ctrl_cmd_t             cmd,
    output mmu_pkg::ctrl_sts_t             sts,
    input  logic                           cfg_we,
    input  logic [mmu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmu_pkg::CFG_W-1:0]      cfg_data,
    input  logic signed [ELEM_WIDTH-1:0]   element_value,
    output logic signed [PROD_W-1:0]       product_value,
    output logic [IDX_W-1:0]               row_index,
    output logic [IDX_W-1:0]               col_index,
    output logic                           last_entry,
    output logic                           result_valid
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SZ_W  = $clog2(DEPTH + 1);
    localparam int LC_W  = $clog2(2 * DEPTH + 1);
    localparam int MUL_W = 2 * ELEM_WIDTH;

    // Step tag carried alongside the data through the pipeline
    typedef struct packed {
        logic             first;
        logic             lastk;
        logic             final_step;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    logic [mmu_pkg::CFG_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0]          m_eff, k_eff, n_eff;
    logic [DIM_W-1:0]          m_run_reg, k_run_reg, n_run_reg;
    logic [SZ_W-1:0]           size_a, size_b;
    logic [LC_W-1:0]           total, pos_reg, pos_inc, b_pos;
    logic                      we_a, we_b;

    logic [IDX_W-1:0]          i_reg, j_reg, t_reg;
    logic [AW-1:0]             a_addr_reg, a_row_reg, b_addr_reg;
    logic                      t_end, j_end, i_end;
    tag_t                      tag0;

    logic [ELEM_WIDTH-1:0]     rd_a, rd_b;
    logic                      s1_valid_reg, s2_valid_reg;
    tag_t                      s1_tag_reg, s2_tag_reg;
    logic signed [MUL_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;

    logic signed [PROD_W-1:0]  out_value_reg;
    logic [IDX_W-1:0]          out_row_reg, out_col_reg;
    logic                      out_last_reg, out_valid_reg;

    // Clamp a size register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [mmu_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > mmu_pkg::CFG_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= mmu_pkg::DIM_RESET;
            inner_reg <= mmu_pkg::DIM_RESET;
            cols_reg  <= mmu_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mmu_pkg::REG_ROWS_A)    rows_reg  <= cfg_data;
            if (cfg_index == mmu_pkg::REG_INNER_DIM) inner_reg <= cfg_data;
            if (cfg_index == mmu_pkg::REG_COLS_B)    cols_reg  <= cfg_data;
        end
    end

    // Load addressing against the sizes in force now
    always_comb
    begin
        m_eff   = eff_dim(rows_reg);
        k_eff   = eff_dim(inner_reg);
        n_eff   = eff_dim(cols_reg);
        size_a  = SZ_W'(m_eff) * SZ_W'(k_eff);
        size_b  = SZ_W'(k_eff) * SZ_W'(n_eff);
        total   = LC_W'(size_a) + LC_W'(size_b);
        pos_inc = pos_reg + LC_W'(1);
        b_pos   = pos_reg - LC_W'(size_a);
        we_a    = cmd.load && (pos_reg < LC_W'(size_a));
        we_b    = cmd.load && !(pos_reg < LC_W'(size_a)) && (b_pos < LC_W'(DEPTH));
    end

    assign sts.load_done = (pos_inc >= total);

    // Load counter and latched run sizes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            pos_reg <= sts.load_done ? '0 : pos_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && sts.load_done)
        begin
            m_run_reg <= m_eff;
            k_run_reg <= k_eff;
            n_run_reg <= n_eff;
        end
    end

    // Element stores
    mmu_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (AW'(pos_reg)),
        .wdata (element_value),
        .raddr (a_addr_reg),
        .rdata (rd_a)
    );

    mmu_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (AW'(b_pos)),
        .wdata (element_value),
        .raddr (b_addr_reg),
        .rdata (rd_b)
    );

    // Step position flags and issue tag
    always_comb
    begin
        t_end            = (DIM_W'(t_reg) == k_run_reg - DIM_W'(1));
        j_end            = (DIM_W'(j_reg) == n_run_reg - DIM_W'(1));
        i_end            = (DIM_W'(i_reg) == m_run_reg - DIM_W'(1));
        tag0.first       = (t_reg == '0);
        tag0.lastk       = t_end;
        tag0.final_step  = t_end && j_end && i_end;
        tag0.row         = i_reg;
        tag0.col         = j_reg;
    end

    assign sts.issue_last = cmd.issue && tag0.final_step;

    // Step counters: t innermost, then column, then row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg      <= '0;
            j_reg      <= '0;
            t_reg      <= '0;
            a_addr_reg <= '0;
            a_row_reg  <= '0;
            b_addr_reg <= '0;
        end
        else if (cmd.load && sts.load_done)
        begin
            i_reg      <= '0;
            j_reg      <= '0;
            t_reg      <= '0;
            a_addr_reg <= '0;
            a_row_reg  <= '0;
            b_addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            if (!t_end)
            begin
                t_reg      <= t_reg + IDX_W'(1);
                a_addr_reg <= a_addr_reg + AW'(1);
                b_addr_reg <= b_addr_reg + AW'(n_run_reg);
            end
            else if (!j_end)
            begin
                t_reg      <= '0;
                j_reg      <= j_reg + IDX_W'(1);
                a_addr_reg <= a_row_reg;
                b_addr_reg <= AW'(j_reg) + AW'(1);
            end
            else
            begin
                t_reg      <= '0;
                j_reg      <= '0;
                i_reg      <= i_reg + IDX_W'(1);
                a_row_reg  <= a_row_reg + AW'(k_run_reg);
                a_addr_reg <= a_row_reg + AW'(k_run_reg);
                b_addr_reg <= '0;
            end
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_tag_reg.lastk;
        end
    end

    // Stage 1: read data arrives; stage 2: product
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= tag0;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= $signed(rd_a) * $signed(rd_b);
    end

    // Stage 3: accumulate, present the finished entry
    assign acc_next = (s2_tag_reg.first ? '0 : acc_reg) + PROD_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_tag_reg.lastk)
        begin
            out_value_reg <= acc_next;
            out_row_reg   <= s2_tag_reg.row;
            out_col_reg   <= s2_tag_reg.col;
            out_last_reg  <= s2_tag_reg.final_step;
        end
    end

    assign sts.final_out = out_valid_reg && out_last_reg;
    assign product_value = out_value_reg;
    assign row_index     = out_row_reg;
    assign col_index     = out_col_reg;
    assign last_entry    = out_last_reg;
    assign result_valid  = out_valid_reg;

endmodule
